[hdl/mm4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_pkg: shared types and constants of the 4x4 fixed-point matrix multiplier
// Widths, the sequencer state type and the tags that travel down the
// multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int MATRIX_DIM    = 4;
    localparam int FRACTION_BITS = 16;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
    localparam int DIM_W  = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W - FRACTION_BITS + DIM_W + 1;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_RUN
    } seq_state_t;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [CELL_W-1:0] idx;
    } tag_t;

    typedef struct packed {
        tag_t              tag;
        logic [CELL_W-1:0] lhs_addr;
        logic [CELL_W-1:0] rhs_addr;
    } issue_t;

endpackage
`default_nettype wire

[hdl/mm4_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_in_if: operand channel
// Carries one left and one right matrix element per beat.
// ----------------------------------------------------------------------------
interface mm4_in_if;
    import mm4_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] lhs_value;
    logic signed [DATA_W-1:0] rhs_value;

    modport source (output valid, output lhs_value, output rhs_value, input ready);
    modport sink   (input valid, input lhs_value, input rhs_value, output ready);

endinterface
`default_nettype wire

[hdl/mm4_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_out_if: result channel
// Carries one result matrix element per beat with its position and flags.
// ----------------------------------------------------------------------------
interface mm4_out_if;
    import mm4_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] product_value;
    logic        [IDX_W-1:0]  product_index;
    logic                     saturated;
    logic                     last_of_run;

    modport source (output valid, output product_value, output product_index,
                    output saturated, output last_of_run, input ready);
    modport sink   (input valid, input product_value, input product_index,
                    input saturated, input last_of_run, output ready);

endinterface
`default_nettype wire

[hdl/matrix_multiply_4x4.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_4x4: 4x4 signed Q16.16 matrix product, result = lhs * rhs
//
// The operand channel takes one beat per matrix position in row-major order,
// each beat carrying the left and the right element of that position. The
// block is ready for operands only while it is loading, and it takes one
// beat per cycle. After the sixteenth beat the sequencer issues the 64
// multiply-accumulate terms to one shared 32x32 multiplier, one per cycle
// while the output is not stalled. The results follow in row-major order,
// with last_of_run on the sixteenth. Loading of the next matrix starts as
// soon as the last term has been issued.
// When the receiver stalls, the finished element waits in the output
// register; the multiply pipeline and sequencer keep running until the next
// element is finished and then hold until the waiting one is taken.
// Reset clears the load position, the sequencer and all valid flags; the
// operand memories are not cleared, since every entry is written before use.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 (
    input  wire logic clk,
    input  wire logic rst_n,
    mm4_in_if.sink    operand,
    mm4_out_if.source result
);
    import mm4_pkg::*;

    logic                     en;
    logic                     wr_en;
    logic [CELL_W-1:0]        wr_addr;
    issue_t                   issue;
    tag_t                     rd_tag;
    logic signed [DATA_W-1:0] lhs_rdata;
    logic signed [DATA_W-1:0] rhs_rdata;

    mm4_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .operand_valid (operand.valid),
        .operand_ready (operand.ready),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .issue         (issue)
    );

    mm4_opstore u_opstore (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .lhs_wdata (operand.lhs_value),
        .rhs_wdata (operand.rhs_value),
        .issue     (issue),
        .rd_tag    (rd_tag),
        .lhs_rdata (lhs_rdata),
        .rhs_rdata (rhs_rdata)
    );

    mm4_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_tag    (rd_tag),
        .lhs_rdata (lhs_rdata),
        .rhs_rdata (rhs_rdata),
        .en        (en),
        .result    (result)
    );

endmodule
`default_nettype wire

[hdl/mm4_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_seq: load and compute sequencer
// Counts loaded positions, then steps row, column and inner index to issue
// one multiply-accumulate term per cycle to the shared unit while en is high.
// ----------------------------------------------------------------------------
module mm4_seq (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   operand_valid,
    output logic                        operand_ready,
    output logic                        wr_en,
    output logic [mm4_pkg::CELL_W-1:0]  wr_addr,
    output mm4_pkg::issue_t             issue
);
    import mm4_pkg::*;

    localparam logic [DIM_W-1:0]  DIM_LAST  = DIM_W'(MATRIX_DIM - 1);
    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS - 1);

    seq_state_t        state_reg, state_next;
    logic [CELL_W-1:0] load_pos_reg, load_pos_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  k_reg, k_next;
    logic              accept;
    logic              step;
    logic              final_term;

    assign accept     = operand_valid && operand_ready;
    assign step       = (state_reg == ST_RUN) && en;
    assign final_term = (row_reg == DIM_LAST) && (col_reg == DIM_LAST) && (k_reg == DIM_LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && (load_pos_reg == CELL_LAST))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step && final_term)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        operand_ready      = (state_reg == ST_LOAD);
        wr_en              = accept;
        wr_addr            = load_pos_reg;
        issue.tag.valid    = (state_reg == ST_RUN);
        issue.tag.first    = (k_reg == '0);
        issue.tag.last     = (k_reg == DIM_LAST);
        issue.tag.idx      = CELL_W'(row_reg * MATRIX_DIM + col_reg);
        issue.lhs_addr     = CELL_W'(row_reg * MATRIX_DIM + k_reg);
        issue.rhs_addr     = CELL_W'(k_reg * MATRIX_DIM + col_reg);
    end

    always_comb
    begin
        load_pos_next = load_pos_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        k_next        = k_reg;
        if (accept)
        begin
            load_pos_next = (load_pos_reg == CELL_LAST) ? '0 : load_pos_reg + 1'b1;
        end
        if (step)
        begin
            if (k_reg == DIM_LAST)
            begin
                k_next = '0;
                if (col_reg == DIM_LAST)
                begin
                    col_next = '0;
                    row_next = (row_reg == DIM_LAST) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            else
            begin
                k_next = k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_pos_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            k_reg        <= k_next;
        end
    end

endmodule
`default_nettype wire

[hdl/mm4_opstore.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_opstore: operand memories
// Holds the left and right matrices, one write port and one registered
// read port each, and carries the term tag alongside the read data.
// ----------------------------------------------------------------------------
module mm4_opstore (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          wr_en,
    input  wire logic [mm4_pkg::CELL_W-1:0]    wr_addr,
    input  wire logic signed [mm4_pkg::DATA_W-1:0] lhs_wdata,
    input  wire logic signed [mm4_pkg::DATA_W-1:0] rhs_wdata,
    input  wire mm4_pkg::issue_t               issue,
    output mm4_pkg::tag_t                      rd_tag,
    output logic signed [mm4_pkg::DATA_W-1:0]  lhs_rdata,
    output logic signed [mm4_pkg::DATA_W-1:0]  rhs_rdata
);
    import mm4_pkg::*;

    logic signed [DATA_W-1:0] left_mem  [CELLS];
    logic signed [DATA_W-1:0] right_mem [CELLS];
    logic signed [DATA_W-1:0] lhs_rdata_reg;
    logic signed [DATA_W-1:0] rhs_rdata_reg;
    tag_t                     tag_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr]  <= lhs_wdata;
            right_mem[wr_addr] <= rhs_wdata;
        end
        if (en)
        begin
            lhs_rdata_reg <= left_mem[issue.lhs_addr];
            rhs_rdata_reg <= right_mem[issue.rhs_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= issue.tag;
        end
    end

    assign rd_tag    = tag_reg;
    assign lhs_rdata = lhs_rdata_reg;
    assign rhs_rdata = rhs_rdata_reg;

endmodule
`default_nettype wire

[hdl/mm4_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_mac: shared multiply-accumulate unit and result register
// Multiplies one operand pair per cycle unless stalled, truncates the product,
// sums the terms of one element, saturates to 32 bits, holds the result beat.
// ----------------------------------------------------------------------------
module mm4_mac (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mm4_pkg::tag_t                     rd_tag,
    input  wire logic signed [mm4_pkg::DATA_W-1:0] lhs_rdata,
    input  wire logic signed [mm4_pkg::DATA_W-1:0] rhs_rdata,
    output logic                                   en,
    mm4_out_if.source                              result
);
    import mm4_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    tag_t                     prod_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     over_hi;
    logic                     over_lo;
    logic                     done;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]         index_reg;
    logic                     sat_reg;
    logic                     last_reg;

    assign done     = prod_tag_reg.valid && prod_tag_reg.last;
    assign en       = !(done && out_valid_reg && !result.ready);
    assign term     = ACC_W'(prod_reg >>> FRACTION_BITS);
    assign acc_next = (prod_tag_reg.first ? '0 : acc_reg) + term;
    assign over_hi  = acc_next > SAT_MAX;
    assign over_lo  = acc_next < SAT_MIN;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(lhs_rdata) * PROD_W'(rhs_rdata);
            if (prod_tag_reg.valid)
            begin
                acc_reg <= acc_next;
            end
            if (done)
            begin
                priority if (over_hi)
                begin
                    value_reg <= SAT_MAX[DATA_W-1:0];
                end
                else if (over_lo)
                begin
                    value_reg <= SAT_MIN[DATA_W-1:0];
                end
                else
                begin
                    value_reg <= acc_next[DATA_W-1:0];
                end
                index_reg <= IDX_W'(prod_tag_reg.idx);
                sat_reg   <= over_hi || over_lo;
                last_reg  <= (prod_tag_reg.idx == CELL_W'(CELLS - 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_tag_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                prod_tag_reg <= rd_tag;
            end
            if (en && done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.product_value = value_reg;
    assign result.product_index = index_reg;
    assign result.saturated     = sat_reg;
    assign result.last_of_run   = last_reg;

endmodule
`default_nettype wire

[hdl/mm4_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_checker: port-level checks of the matrix multiplier
// Tracks operand and result beats, checks stall stability, ordering and count.
// ----------------------------------------------------------------------------
module mm4_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              operand_valid,
    input  wire logic                              operand_ready,
    input  wire logic                              result_valid,
    input  wire logic                              result_ready,
    input  wire logic signed [mm4_pkg::DATA_W-1:0] product_value,
    input  wire logic [mm4_pkg::IDX_W-1:0]         product_index,
    input  wire logic                              saturated,
    input  wire logic                              last_of_run
);
    import mm4_pkg::*;

    localparam int PEND_W = CELL_W + 3;

    logic [CELL_W-1:0] load_cnt_reg;
    logic [CELL_W-1:0] out_cnt_reg;
    logic [PEND_W-1:0] pending_reg;
    logic              in_beat;
    logic              out_beat;
    logic              load_done;

    assign in_beat   = operand_valid && operand_ready;
    assign out_beat  = result_valid && result_ready;
    assign load_done = in_beat && (load_cnt_reg == CELL_W'(CELLS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            out_cnt_reg  <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            if (in_beat)
            begin
                load_cnt_reg <= load_cnt_reg + 1'b1;
            end
            if (out_beat)
            begin
                out_cnt_reg <= out_cnt_reg + 1'b1;
            end
            pending_reg <= pending_reg + (load_done ? PEND_W'(CELLS) : '0)
                           - (out_beat ? PEND_W'(1) : '0);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(product_value)
            && $stable(product_index) && $stable(saturated) && $stable(last_of_run))
        else $error("result beat changed while stalled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> product_index == IDX_W'(out_cnt_reg))
        else $error("result beat out of row-major order");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> last_of_run == (out_cnt_reg == CELL_W'(CELLS - 1)))
        else $error("last_of_run on the wrong result beat");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != '0)
        else $error("result beat without a completed matrix load");

endmodule

bind matrix_multiply_4x4 mm4_checker u_mm4_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .operand_valid (operand.valid),
    .operand_ready (operand.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .product_value (result.product_value),
    .product_index (result.product_index),
    .saturated     (result.saturated),
    .last_of_run   (result.last_of_run)
);
`default_nettype wire
